// File: hdl/mvcf_pkg.sv
// Shared types and codes for the memory value candidate filter.
`default_nettype none
package mvcf_pkg;

    localparam logic [1:0] FN_START  = 2'd0;
    localparam logic [1:0] FN_FILTER = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_NE = 3'd1;
    localparam logic [2:0] CMP_LT = 3'd2;
    localparam logic [2:0] CMP_GT = 3'd3;
    localparam logic [2:0] CMP_LE = 3'd4;
    localparam logic [2:0] CMP_GE = 3'd5;

    localparam logic [2:0] REG_SIZE_CODE  = 3'd0;
    localparam logic [2:0] REG_ALIGN_CODE = 3'd1;
    localparam logic [2:0] REG_SLOT_TOTAL = 3'd2;
    localparam logic [2:0] REG_BASE       = 3'd3;
    localparam logic [2:0] REG_COMPARE    = 3'd4;
    localparam logic [2:0] REG_TARGET     = 3'd5;
    localparam logic [2:0] REG_AGAINST    = 3'd6;

    typedef struct packed {
        logic        cand;
        logic [31:0] prev;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } t_state;

    function automatic logic [1:0] width_shift(input logic [1:0] code);
        logic [1:0] sh;
        case (code)
            SZ_HALF: sh = 2'd1;
            SZ_WORD: sh = 2'd2;
            default: sh = 2'd0;
        endcase
        return sh;
    endfunction

endpackage
`default_nettype wire

// File: hdl/memory_value_candidate_filter.sv
// Top level of the memory value candidate filter: slot memory and update logic.
//
// Input channel: i_valid / o_stall carry one item (func, slot index, memory
// word). Output channel: o_valid / i_stall return one result item per input
// item, in order. The user must write configuration registers through i_cfg_we,
// i_cfg_idx and i_cfg_data while the block is idle; it is not enforced.
//
// For each item the slot entry (candidate mark and previous value) is read
// from a one-port-read, one-port-write memory in the accept cycle, then
// modified and written back in S_CALC once the output register is free. No
// new item is accepted until that write-back; the result is loaded into the
// output register together with the write-back.
//
// Reset clears the configuration to its defaults, the survivor count and the
// search-active flag. The slot memory is not cleared; every slot must see a
// start item before it is filtered or read.
// When the receiver stalls, the result holds in the output register and one
// further item can be accepted and read; its write-back waits until the
// output register frees.
`default_nettype none
module memory_value_candidate_filter
    import mvcf_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_slot_index,
    input  wire logic [31:0] i_current_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_slot_ok,
    output logic             o_still_candidate,
    output logic [31:0]      o_slot_address,
    output logic [31:0]      o_masked_now,
    output logic [31:0]      o_earlier_word,
    output logic [16:0]      o_survivors,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CW = 21;

    // configuration
    logic [1:0]  r_size_code;
    logic [1:0]  r_align_code;
    logic [16:0] r_slot_total;
    logic [31:0] r_region_base;
    logic [2:0]  r_compare_kind;
    logic [31:0] r_target_word;
    logic        r_against_previous;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_code        <= SZ_BYTE;
            r_align_code       <= SZ_BYTE;
            r_slot_total       <= 17'd1;
            r_region_base      <= '0;
            r_compare_kind     <= CMP_EQ;
            r_target_word      <= '0;
            r_against_previous <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SIZE_CODE:  r_size_code        <= i_cfg_data[1:0];
                REG_ALIGN_CODE: r_align_code       <= i_cfg_data[1:0];
                REG_SLOT_TOTAL: r_slot_total       <= i_cfg_data[16:0];
                REG_BASE:       r_region_base      <= i_cfg_data;
                REG_COMPARE:    r_compare_kind     <= i_cfg_data[2:0];
                REG_TARGET:     r_target_word      <= i_cfg_data;
                REG_AGAINST:    r_against_previous <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control
    t_state      r_state;
    t_state      n_state;
    logic        r_active;
    logic        n_active;
    logic [16:0] r_count;
    logic [16:0] n_count;

    logic [1:0]  r_func;
    logic [15:0] r_slot;
    logic [31:0] r_word;

    logic        in_fire;
    logic        out_free;
    logic        done;

    assign o_stall  = (r_state != S_IDLE);
    assign in_fire  = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;
    assign done     = (r_state == S_CALC) && out_free;

    // slot memory
    t_entry          r_mem [MAX_SLOTS];
    t_entry          r_rd;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd <= r_mem[AW'(i_slot_index)];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_func <= i_func;
            r_slot <= i_slot_index;
            r_word <= i_current_word;
        end
    end

    // update logic
    logic [1:0]  sz_sh;
    logic [1:0]  al_sh;
    logic [1:0]  st_sh;
    logic [31:0] mask;
    logic [31:0] now;
    logic [31:0] addr;
    logic        start;
    logic        slot_lt_max;
    logic [16:0] load;
    logic        ok;
    logic [31:0] earlier;
    logic [31:0] ref_word;
    logic        pass;
    logic        cand;

    always_comb begin
        sz_sh = width_shift(r_size_code);
        al_sh = width_shift(r_align_code);
        st_sh = (al_sh < sz_sh) ? sz_sh : al_sh;
        case (sz_sh)
            2'd1:    mask = 32'h0000_FFFF;
            2'd2:    mask = 32'hFFFF_FFFF;
            default: mask = 32'h0000_00FF;
        endcase
        now  = r_word & mask;
        addr = r_region_base + ({16'd0, r_slot} << st_sh);

        start       = (r_func == FN_START);
        slot_lt_max = ({5'd0, r_slot} < CW'(MAX_SLOTS));
        load        = ({4'd0, r_slot_total} > CW'(MAX_SLOTS)) ? 17'(MAX_SLOTS)
                                                              : r_slot_total;
        n_active = r_active || start;
        n_count  = start ? load : r_count;
        ok       = n_active && ({1'b0, r_slot} < r_slot_total) && slot_lt_max;

        ref_word = r_against_previous ? r_rd.prev : r_target_word;
        case (r_compare_kind)
            CMP_EQ:  pass = (now == ref_word);
            CMP_NE:  pass = (now != ref_word);
            CMP_LT:  pass = (now <  ref_word);
            CMP_GT:  pass = (now >  ref_word);
            CMP_LE:  pass = (now <= ref_word);
            CMP_GE:  pass = (now >= ref_word);
            default: pass = 1'b0;
        endcase

        wr_en        = 1'b0;
        wr_addr      = AW'(r_slot);
        wr_data.cand = 1'b1;
        wr_data.prev = now;
        earlier      = '0;
        cand         = 1'b0;
        if (ok) begin
            if (start) begin
                wr_en = 1'b1;
                cand  = 1'b1;
            end else begin
                earlier = r_rd.prev;
                cand    = r_rd.cand;
                if (r_func == FN_FILTER && r_rd.cand) begin
                    wr_en = 1'b1;
                    if (!pass) begin
                        wr_data.cand = 1'b0;
                        wr_data.prev = r_rd.prev;
                        cand         = 1'b0;
                        if (n_count != 17'd0) begin
                            n_count = n_count - 17'd1;
                        end
                    end
                end
            end
        end
        wr_en = wr_en && done;

        unique case (r_state)
            S_IDLE:  n_state = in_fire ? S_CALC : S_IDLE;
            S_CALC:  n_state = out_free ? S_IDLE : S_CALC;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= 1'b0;
            r_count  <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_active <= n_active;
                r_count  <= n_count;
                o_valid  <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            o_slot_ok         <= ok;
            o_still_candidate <= cand;
            o_slot_address    <= addr;
            o_masked_now      <= now;
            o_earlier_word    <= earlier;
            o_survivors       <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for memory_value_candidate_filter: directed and random items.
module tb_top;
    import mvcf_pkg::*;

    localparam int unsigned SLOT_CAP     = 65536;
    localparam int unsigned RANDOM_ITEMS = 1550;
    localparam int unsigned QUIET_LIMIT  = 5000;

    localparam logic [1:0] FN_SPARE    = 2'd3;
    localparam logic [1:0] SZ_SPARE    = 2'd3;
    localparam logic [2:0] CMP_SPARE_A = 3'd6;
    localparam logic [2:0] CMP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] slot;
        logic [31:0] word;
    } t_scan_item;

    typedef struct packed {
        logic        ok;
        logic        cand;
        logic [31:0] addr;
        logic [31:0] now;
        logic [31:0] earlier;
        logic [16:0] surv;
    } t_slot_report;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [1:0]  i_func         = FN_READ;
    logic [15:0] i_slot_index   = '0;
    logic [31:0] i_current_word = '0;
    logic        i_stall        = 1'b0;
    logic        i_cfg_we       = 1'b0;
    logic [2:0]  i_cfg_idx      = REG_SIZE_CODE;
    logic [31:0] i_cfg_data     = '0;
    logic        o_stall;
    logic        o_valid;
    logic        o_slot_ok;
    logic        o_still_candidate;
    logic [31:0] o_slot_address;
    logic [31:0] o_masked_now;
    logic [31:0] o_earlier_word;
    logic [16:0] o_survivors;

    memory_value_candidate_filter #(.MAX_SLOTS(SLOT_CAP)) i_dut (.*);

    always #5 i_clk = ~i_clk;

    // register copies
    logic [1:0]  size_sel     = SZ_BYTE;
    logic [1:0]  align_sel    = SZ_BYTE;
    logic [16:0] slot_limit   = 17'd1;
    logic [31:0] base_addr    = '0;
    logic [2:0]  cmp_sel      = CMP_EQ;
    logic [31:0] target_val   = '0;
    logic        against_prev = 1'b0;

    // slot state as the block should hold it
    logic        cand_mark  [SLOT_CAP];
    logic [31:0] prior_word [SLOT_CAP];
    logic [16:0] survivor_cnt = '0;
    logic        searching    = 1'b0;

    t_scan_item   scan_items   [$];
    t_slot_report slot_reports [$];
    bit           slot_used    [SLOT_CAP];
    int unsigned  used_list    [$];

    bit          took       = 1'b0;
    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_checked  = 0;
    int unsigned n_errors   = 0;
    int unsigned n_settings = 0;
    int unsigned n_dropped  = 0;
    int unsigned n_floor    = 0;
    int unsigned quiet      = 0;

    function automatic int unsigned byte_count(input logic [1:0] code);
        case (code)
            SZ_HALF: return 2;
            SZ_WORD: return 4;
            default: return 1;
        endcase
    endfunction

    function automatic logic [31:0] mask_of(input logic [1:0] code);
        case (code)
            SZ_HALF: return 32'h0000_ffff;
            SZ_WORD: return 32'hffff_ffff;
            default: return 32'h0000_00ff;
        endcase
    endfunction

    function automatic logic cmp_holds(input logic [2:0] kind, input logic [31:0] a, b);
        case (kind)
            CMP_EQ:  return a == b;
            CMP_NE:  return a != b;
            CMP_LT:  return a < b;
            CMP_GT:  return a > b;
            CMP_LE:  return a <= b;
            CMP_GE:  return a >= b;
            default: return 1'b0;
        endcase
    endfunction

    // applies one item to the slot state and returns the result the block owes
    function automatic t_slot_report filter_step(input t_scan_item it);
        t_slot_report r;
        int unsigned  stride;
        logic [31:0]  ref_val;
        r      = '0;
        stride = byte_count(align_sel);
        if (stride < byte_count(size_sel)) stride = byte_count(size_sel);
        r.addr = base_addr + it.slot * stride;
        r.now  = it.word & mask_of(size_sel);
        if (it.func == FN_START) begin
            searching    = 1'b1;
            survivor_cnt = (slot_limit > SLOT_CAP) ? 17'(SLOT_CAP) : slot_limit;
        end
        r.ok = searching && (slot_limit > it.slot);
        if (r.ok) begin
            if (it.func == FN_START) begin
                cand_mark[it.slot]  = 1'b1;
                prior_word[it.slot] = r.now;
            end else begin
                r.earlier = prior_word[it.slot];
                if (it.func == FN_FILTER && cand_mark[it.slot]) begin
                    ref_val = against_prev ? r.earlier : target_val;
                    if (cmp_holds(cmp_sel, r.now, ref_val)) begin
                        prior_word[it.slot] = r.now;
                    end else begin
                        cand_mark[it.slot] = 1'b0;
                        n_dropped++;
                        if (survivor_cnt != 0) survivor_cnt--;
                        else n_floor++;
                    end
                end
            end
            r.cand = cand_mark[it.slot];
        end
        r.surv = survivor_cnt;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            n_errors++;
        end
    endfunction

    // input driver
    always @(negedge i_clk) begin : feed
        t_scan_item nxt;
        logic       calm;
        calm = (n_accepted >= 500) && (n_accepted < 800);
        if (!i_valid || took) begin
            if (scan_items.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
                nxt = scan_items.pop_front();
                i_valid        <= 1'b1;
                i_func         <= nxt.func;
                i_slot_index   <= nxt.slot;
                i_current_word <= nxt.word;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < 8);
    end

    // result checker, input capture and watchdog
    always @(posedge i_clk) begin : watch
        t_slot_report want;
        logic         out_taken;
        took      = i_rst_n && i_valid && !o_stall;
        out_taken = i_rst_n && o_valid && !i_stall;
        if (out_taken) begin
            if (slot_reports.size() == 0) begin
                $error("result with no item outstanding: slot_address %h", o_slot_address);
                n_errors++;
            end else begin
                want = slot_reports.pop_front();
                check_field("slot_ok", 32'(want.ok), 32'(o_slot_ok));
                check_field("still_candidate", 32'(want.cand), 32'(o_still_candidate));
                check_field("slot_address", want.addr, o_slot_address);
                check_field("masked_now", want.now, o_masked_now);
                check_field("earlier_word", want.earlier, o_earlier_word);
                check_field("survivors", 32'(want.surv), 32'(o_survivors));
                n_checked++;
            end
        end
        if (took) begin
            slot_reports.push_back(filter_step('{i_func, i_slot_index, i_current_word}));
            n_accepted++;
        end
        quiet = (took || out_taken) ? 0 : quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    task automatic put(input logic [1:0] fn, input logic [15:0] slot, input logic [31:0] word);
        scan_items.push_back('{fn, slot, word});
        n_queued++;
        if (fn == FN_START && slot_limit > slot && !slot_used[slot]) begin
            slot_used[slot] = 1'b1;
            used_list.push_back(slot);
        end
    endtask

    task automatic drain();
        while (n_accepted != n_queued || slot_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    task automatic program_regs(input logic [1:0] sz, input logic [1:0] al,
                                input logic [16:0] tot, input logic [31:0] base,
                                input logic [2:0] cmp, input logic [31:0] tgt,
                                input logic agp);
        write_reg(REG_SIZE_CODE, 32'(sz));
        write_reg(REG_ALIGN_CODE, 32'(al));
        write_reg(REG_SLOT_TOTAL, 32'(tot));
        write_reg(REG_BASE, base);
        write_reg(REG_COMPARE, 32'(cmp));
        write_reg(REG_TARGET, tgt);
        write_reg(REG_AGAINST, 32'(agp));
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        size_sel     = sz;
        align_sel    = al;
        slot_limit   = tot;
        base_addr    = base;
        cmp_sel      = cmp;
        target_val   = tgt;
        against_prev = agp;
        n_settings++;
    endtask

    // word close to a reference value, random above the value width
    function automatic logic [31:0] near_word(input logic [31:0] centre);
        logic [31:0] m;
        logic [31:0] v;
        m = mask_of(size_sel);
        case ($urandom_range(0, 5))
            0:       v = centre;
            1:       v = centre + 1;
            2:       v = centre - 1;
            3:       v = '0;
            4:       v = m;
            default: v = $urandom;
        endcase
        return (v & m) | ($urandom & ~m);
    endfunction

    task automatic random_phase();
        logic [2:0]  cmp_codes [6];
        logic [1:0]  sz;
        logic [1:0]  al;
        logic [16:0] tot;
        logic [31:0] base;
        logic [31:0] tgt;
        logic [2:0]  cmp;
        logic        agp;
        int unsigned live [$];
        int unsigned rounds;
        int unsigned pick;
        int unsigned s;
        logic [1:0]  rd_fn;
        cmp_codes = '{CMP_EQ, CMP_NE, CMP_LT, CMP_GT, CMP_LE, CMP_GE};
        pick = $urandom_range(0, 20);
        sz   = (pick == 0) ? SZ_SPARE : (pick < 7) ? SZ_BYTE : (pick < 14) ? SZ_HALF : SZ_WORD;
        pick = $urandom_range(0, 20);
        al   = (pick == 0) ? SZ_SPARE : (pick < 7) ? SZ_BYTE : (pick < 14) ? SZ_HALF : SZ_WORD;
        pick = $urandom_range(0, 19);
        tot  = (pick == 0) ? 17'(SLOT_CAP) : (pick == 1) ? 17'($urandom_range(1, SLOT_CAP)) :
               (pick == 2) ? 17'd1 : 17'($urandom_range(2, 40));
        pick = $urandom_range(0, 9);
        base = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom;
        cmp  = ($urandom_range(0, 14) == 0) ? ($urandom_range(0, 1) ? CMP_SPARE_A : CMP_SPARE_B)
                                            : cmp_codes[$urandom_range(0, 5)];
        pick = $urandom_range(0, 9);
        tgt  = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff :
               (pick < 8) ? ($urandom & mask_of(sz)) : $urandom;
        agp  = $urandom_range(0, 1);
        program_regs(sz, al, tot, base, cmp, tgt, agp);

        if (tot <= 48) begin
            for (s = 0; s < tot; s++) live.push_back(s);
        end else begin
            live.push_back(0);
            live.push_back(tot - 1);
            repeat (22) live.push_back($urandom_range(0, tot - 1));
        end
        foreach (live[k]) put(FN_START, 16'(live[k]), near_word(tgt));
        if (tot < SLOT_CAP) begin
            repeat (2) put(FN_START, 16'($urandom_range(tot, SLOT_CAP - 1)), $urandom);
        end
        drain();

        rounds = $urandom_range(2, 4);
        repeat (rounds) begin
            foreach (live[k]) begin
                s     = live[k];
                pick  = $urandom_range(0, 99);
                rd_fn = ($urandom_range(0, 3) == 0) ? FN_SPARE : FN_READ;
                if (pick < 70) begin
                    put(FN_FILTER, 16'(s), near_word(against_prev ? prior_word[s] : tgt));
                end else if (pick < 85) begin
                    put(rd_fn, 16'(s), $urandom);
                end else if (pick < 92) begin
                    // any slot written so far, often outside the current region
                    put($urandom_range(0, 1) ? FN_FILTER : rd_fn,
                        16'(used_list[$urandom_range(0, used_list.size() - 1)]), $urandom);
                end else if (pick < 96) begin
                    put(FN_START, 16'(s), near_word(tgt));
                end else begin
                    put(FN_FILTER, 16'(s), $urandom);
                end
            end
            drain();
        end
    endtask

    initial begin : stimulus
        int unsigned directed_total;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // byte values, region base wrapping, target wider than the value, spare func as read
        program_regs(SZ_BYTE, SZ_BYTE, 17'd4, 32'hffff_fffe, CMP_EQ, 32'h0000_01ff, 1'b0);
        put(FN_START, 16'd0, 32'hffff_ffff);
        put(FN_START, 16'd1, 32'h1234_5600);
        put(FN_START, 16'd2, 32'h0000_00ab);
        put(FN_START, 16'd3, 32'h8000_0001);
        put(FN_START, 16'd9, 32'h0000_0055);
        put(FN_FILTER, 16'd0, 32'h0000_01ff);
        put(FN_READ, 16'd0, 32'h0);
        put(FN_SPARE, 16'd1, 32'hffff_ffff);
        drain();

        // shrink the region and restart: the count reloads below the marks still set
        program_regs(SZ_BYTE, SZ_BYTE, 17'd2, 32'h0, CMP_EQ, 32'h0000_01ff, 1'b0);
        put(FN_START, 16'd0, 32'h0);
        put(FN_FILTER, 16'd3, 32'h0000_0001);
        drain();

        // spare compare code drops every slot, survivor count held at zero
        program_regs(SZ_BYTE, SZ_BYTE, 17'd4, 32'h0, CMP_SPARE_A, 32'h0, 1'b0);
        put(FN_FILTER, 16'd0, 32'h0);
        put(FN_FILTER, 16'd1, 32'h0000_0000);
        put(FN_FILTER, 16'd2, 32'hffff_ff00);
        put(FN_FILTER, 16'd3, 32'h0000_0001);
        drain();

        // spare size and stride codes, full region, top slot, compare with previous
        program_regs(SZ_SPARE, SZ_SPARE, 17'(SLOT_CAP), 32'h0, CMP_GE, 32'h0, 1'b1);
        put(FN_START, 16'hffff, 32'hffff_ffff);
        put(FN_FILTER, 16'hffff, 32'h0000_00ff);
        put(FN_FILTER, 16'hffff, 32'h0000_00fe);
        put(FN_READ, 16'hffff, 32'h0);
        drain();

        // four-byte values, stride raised to the value width, address wraps
        program_regs(SZ_WORD, SZ_HALF, 17'(SLOT_CAP), 32'hffff_fff0, CMP_LT, 32'hffff_ffff, 1'b0);
        put(FN_START, 16'h8000, 32'hdead_beef);
        put(FN_FILTER, 16'h8000, 32'hffff_fffe);
        put(FN_FILTER, 16'h8000, 32'hffff_ffff);
        drain();

        program_regs(SZ_HALF, SZ_WORD, 17'd3, 32'h0000_1000, CMP_SPARE_B, 32'h0, 1'b0);
        put(FN_START, 16'd2, 32'h0001_abcd);
        put(FN_FILTER, 16'd2, 32'h0000_abcd);
        drain();

        directed_total = n_queued;
        while (n_queued < directed_total + RANDOM_ITEMS) random_phase();

        drain();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d items under %0d register settings.", n_checked, n_settings);
        $display("Filtering dropped %0d slots; %0d drops found the survivor count at zero.",
                 n_dropped, n_floor);
        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/mvcf_pkg.sv
hdl/memory_value_candidate_filter.sv
dv/tb_top.sv
